@@ rtl/core/b64_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64_pkg
// Shared types, constants and the alphabet lookup of the Base64 encoder.
// ----------------------------------------------------------------------------
package b64_pkg;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  localparam logic [7:0] PAD_CHAR   = 8'h3D;
  localparam logic [7:0] PLUS_CHAR  = 8'h2B;
  localparam logic [7:0] SLASH_CHAR = 8'h2F;

  // one encoded byte: up to four characters
  typedef struct packed {
    logic [1:0]      cnt_m1;
    logic [3:0][5:0] sym;
    logic [3:0]      pad;
    logic            last;
  } job_t;

  function automatic logic [7:0] sym_char(logic [5:0] v);
    logic [7:0] c;
    if (v < 6'd26) begin
      c = 8'h41 + {2'b00, v};
    end else if (v < 6'd52) begin
      c = 8'h61 + {2'b00, v} - 8'd26;
    end else if (v < 6'd62) begin
      c = 8'h30 + {2'b00, v} - 8'd52;
    end else if (v == 6'd62) begin
      c = PLUS_CHAR;
    end else begin
      c = SLASH_CHAR;
    end
    return c;
  endfunction

endpackage

@@ rtl/core/b64_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64_front
// Accepts raw bytes, tracks the group phase and carried bits, and turns each
// byte into a request of one to four symbols for the character queue.
// ----------------------------------------------------------------------------
module b64_front import b64_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] in_byte
  input  logic       in_tlast,   // last_byte
  input  logic       q_full,
  output logic       q_push,
  output job_t       q_job
);

  logic [1:0] phase_r, phase_nxt;
  logic [3:0] carry_r, carry_nxt;

  assign in_tready = !q_full;
  assign q_push    = in_tvalid && !q_full;

  always_comb begin
    phase_nxt     = phase_r;
    carry_nxt     = carry_r;
    q_job.sym     = '0;
    q_job.pad     = '0;
    q_job.cnt_m1  = 2'd0;
    q_job.last    = in_tlast;
    unique case (phase_r)
      2'd1: begin
        q_job.sym[0] = {carry_r[1:0], in_tdata[7:4]};
        if (in_tlast) begin
          q_job.sym[1] = {in_tdata[3:0], 2'b00};
          q_job.pad[2] = 1'b1;
          q_job.cnt_m1 = 2'd2;
          phase_nxt    = 2'd0;
          carry_nxt    = 4'd0;
        end else begin
          phase_nxt    = 2'd2;
          carry_nxt    = in_tdata[3:0];
        end
      end
      2'd2: begin
        q_job.sym[0] = {carry_r, in_tdata[7:6]};
        q_job.sym[1] = in_tdata[5:0];
        q_job.cnt_m1 = 2'd1;
        phase_nxt    = 2'd0;
        carry_nxt    = 4'd0;
      end
      default: begin
        q_job.sym[0] = in_tdata[7:2];
        if (in_tlast) begin
          q_job.sym[1] = {in_tdata[1:0], 4'b0000};
          q_job.pad[2] = 1'b1;
          q_job.pad[3] = 1'b1;
          q_job.cnt_m1 = 2'd3;
          phase_nxt    = 2'd0;
          carry_nxt    = 4'd0;
        end else begin
          phase_nxt    = 2'd1;
          carry_nxt    = {2'b00, in_tdata[1:0]};
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= 2'd0;
      carry_r <= 4'd0;
    end else if (q_push) begin
      phase_r <= phase_nxt;
      carry_r <= carry_nxt;
    end
  end

endmodule

@@ rtl/core/b64_fifo.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64_fifo
// Short request queue between the byte front end and the character back end.
// ----------------------------------------------------------------------------
module b64_fifo import b64_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t wr_job,
  input  logic pop,
  output job_t rd_job,
  output logic full,
  output logic empty
);

  job_t               mem_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_r;
  logic [FIFO_AW-1:0] rd_ptr_r;
  logic [FIFO_CW-1:0] cnt_r;

  assign full   = (cnt_r == FIFO_CW'(FIFO_DEPTH));
  assign empty  = (cnt_r == '0);
  assign rd_job = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + FIFO_AW'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + FIFO_AW'(1);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + FIFO_CW'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - FIFO_CW'(1);
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full)) else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(pop && empty)) else $error("pop from empty queue");
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= FIFO_CW'(FIFO_DEPTH)) else $error("queue count out of range");
  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r != '0 && cnt_r != FIFO_CW'(FIFO_DEPTH)) |-> (wr_ptr_r != rd_ptr_r))
    else $error("pointers disagree with count");

endmodule

@@ rtl/core/b64_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64_back
// Walks the characters of the queued request at the head and drives them one
// per cycle into the output register, pausing while out_tready holds it full.
// ----------------------------------------------------------------------------
module b64_back import b64_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  job_t       q_job,
  input  logic       q_empty,
  output logic       q_pop,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_char
  output logic       out_tlast   // last_char
);

  logic [1:0] idx_r, idx_nxt;
  logic       vld_r, vld_nxt;
  logic [7:0] char_r, char_nxt;
  logic       last_r, last_nxt;
  logic       load;
  logic       at_end;

  assign load   = !q_empty && (!vld_r || out_tready);
  assign at_end = (idx_r == q_job.cnt_m1);
  assign q_pop  = load && at_end;

  always_comb begin
    idx_nxt  = idx_r;
    vld_nxt  = vld_r;
    char_nxt = char_r;
    last_nxt = last_r;
    if (vld_r && out_tready) begin
      vld_nxt = 1'b0;
    end
    if (load) begin
      vld_nxt  = 1'b1;
      char_nxt = q_job.pad[idx_r] ? PAD_CHAR : sym_char(q_job.sym[idx_r]);
      last_nxt = at_end && q_job.last;
      idx_nxt  = at_end ? 2'd0 : idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= 2'd0;
      vld_r <= 1'b0;
    end else begin
      idx_r <= idx_nxt;
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    char_r <= char_nxt;
    last_r <= last_nxt;
  end

  assign out_tvalid = vld_r;
  assign out_tdata  = char_r;
  assign out_tlast  = last_r;

  a_idx_in_job: assert property (@(posedge clk) disable iff (!rst_n)
    !q_empty |-> (idx_r <= q_job.cnt_m1)) else $error("char index past request");
  a_idx_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_empty |-> (idx_r == 2'd0)) else $error("char index left mid request");
  a_last_pad: assert property (@(posedge clk) disable iff (!rst_n)
    (load && q_job.pad[idx_r]) |=> (out_tdata == PAD_CHAR))
    else $error("pad character lost");

endmodule

@@ rtl/core/base64_stream_encoder.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// base64_stream_encoder
// Streaming Base64 encoder with the standard alphabet and '=' padding.
// ----------------------------------------------------------------------------
// Each input byte (in_tlast marks the final byte of a message) becomes one to
// four ASCII characters on the output stream, out_tlast on the final one.
// A byte is accepted whenever the four-entry request queue has room; its
// characters pass through the queue and then the output register.
// Characters leave through a single output register at one per cycle while
// out_tready is high, so a byte occupies the back end until all of its
// characters (one to four) have been loaded. Over full groups three bytes
// become four characters, bounded by the one-character output channel.
// ----------------------------------------------------------------------------
module base64_stream_encoder import b64_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] in_byte
  input  logic       in_tlast,   // last_byte
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_char
  output logic       out_tlast   // last_char
);

  job_t push_job;
  job_t head_job;
  logic q_push;
  logic q_pop;
  logic q_full;
  logic q_empty;

  b64_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_job     (push_job)
  );

  b64_fifo u_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (q_push),
    .wr_job (push_job),
    .pop    (q_pop),
    .rd_job (head_job),
    .full   (q_full),
    .empty  (q_empty)
  );

  b64_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_job      (head_job),
    .q_empty    (q_empty),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule
